@@ hdl/jet_pkg.sv @@
// ----------------------------------------------------------------------------
// jet_pkg
// Types, codes and character helpers shared by the JSON event tokenizer.
// ----------------------------------------------------------------------------
package jet_pkg;

  typedef enum logic [3:0] {
    EV_OBJ_START = 4'd0,
    EV_OBJ_END   = 4'd1,
    EV_ARR_START = 4'd2,
    EV_ARR_END   = 4'd3,
    EV_KEY_CHAR  = 4'd4,
    EV_KEY_END   = 4'd5,
    EV_STR_CHAR  = 4'd6,
    EV_STR_END   = 4'd7,
    EV_NULL      = 4'd8,
    EV_TRUE      = 4'd9,
    EV_FALSE     = 4'd10,
    EV_NUM_CHAR  = 4'd11,
    EV_NUM_END   = 4'd12,
    EV_DOC_END   = 4'd13,
    EV_ERROR     = 4'd14
  } event_kind_e;

  typedef enum logic [3:0] {
    ERR_EMPTY      = 4'd0,
    ERR_NOT_SINGLE = 4'd1,
    ERR_LITERAL    = 4'd2,
    ERR_NUMBER     = 4'd3,
    ERR_ESCAPE     = 4'd4,
    ERR_UNTERM     = 4'd5,
    ERR_ARR_COMMA  = 4'd6,
    ERR_KEY_START  = 4'd7,
    ERR_COLON      = 4'd8,
    ERR_OBJ_COMMA  = 4'd9,
    ERR_TOO_DEEP   = 4'd10
  } error_code_e;

  localparam logic [7:0] CtrlLimit = 8'h20;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  ch;
    logic [15:0] cnt;
    logic [3:0]  err;
  } jet_event_t;

  // all events caused by one input byte
  typedef struct packed {
    jet_event_t [2:0] ev;
    logic [1:0]       num;
    logic [31:0]      pos;
  } jet_bundle_t;

  function automatic jet_event_t mk_ev(input event_kind_e k, input logic [7:0] c,
                                       input logic [15:0] n, input error_code_e e);
    jet_event_t r;
    r.kind = k;
    r.ch   = c;
    r.cnt  = n;
    r.err  = e;
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h0A) || (b == 8'h0D) || (b == 8'h09);
  endfunction

  function automatic logic is_num_char(input logic [7:0] b);
    return (b == ".") || ((b >= "0") && (b <= "9")) || (b == "e") || (b == "E") ||
           (b == "+") || (b == "-");
  endfunction

  // zero marks an escape outside the simple set
  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      "\"":    r = "\"";
      "\\":    r = "\\";
      "/":     r = "/";
      "b":     r = 8'h08;
      "f":     r = 8'h0C;
      "n":     r = 8'h0A;
      "r":     r = 8'h0D;
      "t":     r = 8'h09;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // word 0 null, 1 true, 2 false
  function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
    logic [7:0] r;
    case ({w, i})
      {2'd0, 3'd1}: r = "u";
      {2'd0, 3'd2}: r = "l";
      {2'd0, 3'd3}: r = "l";
      {2'd1, 3'd1}: r = "r";
      {2'd1, 3'd2}: r = "u";
      {2'd1, 3'd3}: r = "e";
      {2'd2, 3'd1}: r = "a";
      {2'd2, 3'd2}: r = "l";
      {2'd2, 3'd3}: r = "s";
      {2'd2, 3'd4}: r = "e";
      default:      r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] w);
    return (w == 2'd2) ? 3'd5 : 3'd4;
  endfunction

endpackage

@@ hdl/jet_if.sv @@
// ----------------------------------------------------------------------------
// jet_if
// Channel interfaces of the JSON event tokenizer: bytes, events, config.
// ----------------------------------------------------------------------------
interface jet_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;
  modport source (output valid, char_byte, is_last, input ready);
  modport sink   (input valid, char_byte, is_last, output ready);
endinterface

interface jet_event_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [7:0]  char_value;
  logic [15:0] item_count;
  logic [3:0]  error_code;
  logic [31:0] byte_position;
  logic        last_of_run;
  modport source (output valid, event_kind, char_value, item_count, error_code,
                  byte_position, last_of_run, input ready);
  modport sink   (input valid, event_kind, char_value, item_count, error_code,
                  byte_position, last_of_run, output ready);
endinterface

interface jet_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] depth_limit;
  modport source (output valid, depth_limit, input ready);
  modport sink   (input valid, depth_limit, output ready);
endinterface

@@ hdl/json_event_tokenizer.sv @@
// ----------------------------------------------------------------------------
// json_event_tokenizer
// Streaming JSON structure checker giving one event stream per document.
// ----------------------------------------------------------------------------
// Usage:
//  in_i  : one document byte per item, is_last on the final byte.
//  out_o : events, each with the byte position that caused it; last_of_run
//          marks the last event of one byte. A byte causes 0 to 3 events.
//  cfg_i : depth_limit, always ready; write it only while the block is idle.
// Timing: a byte is taken every cycle while the two-group event queue has
//  room; its events are written into the queue on acceptance. Events leave
//  at one per cycle while the receiver is ready, and input stalls once both
//  queue slots are full.
// The top of the container stack lives in registers; the entries below it
//  sit in a single-port-write, registered-read memory whose next entry is
//  prefetched each cycle, so a close does not wait for a memory read.
// Reset: parser back to expecting a root value, position 0, depth_limit 32,
//  queue empty. The stack memory needs no clearing.
// A stalled receiver holds the current event steady and backs up the input.
// ----------------------------------------------------------------------------
module json_event_tokenizer #(
  parameter int STACK_DEPTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jet_byte_if.sink  in_i,
  jet_event_if.source out_o,
  jet_cfg_if.sink   cfg_i
);
  import jet_pkg::*;

  logic [5:0]  depth_limit_q;
  logic        accept, q_ready;
  jet_bundle_t bundle;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = q_ready;
  assign accept      = in_i.valid && q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_limit_q <= 6'd32;
    end else if (cfg_i.valid) begin
      depth_limit_q <= cfg_i.depth_limit;
    end
  end

  jet_step #(.STACK_DEPTH(STACK_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_byte_i   (in_i.char_byte),
    .is_last_i     (in_i.is_last),
    .depth_limit_i (depth_limit_q),
    .bundle_o      (bundle)
  );

  jet_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept && (bundle.num != 2'd0)),
    .bundle_i (bundle),
    .ready_o  (q_ready),
    .out_o    (out_o)
  );

endmodule

@@ hdl/jet_stack.sv @@
// ----------------------------------------------------------------------------
// jet_stack
// Container stack memory: one write, one registered read, write forwarding.
// ----------------------------------------------------------------------------
module jet_stack #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 17
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/jet_step.sv @@
// ----------------------------------------------------------------------------
// jet_step
// Per-byte parser step: phase state, top of stack in registers, the rest of
// the stack in memory, up to three events per byte.
// ----------------------------------------------------------------------------
module jet_step #(
  parameter int STACK_DEPTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          char_byte_i,
  input  logic                is_last_i,
  input  logic [5:0]          depth_limit_i,
  output jet_pkg::jet_bundle_t bundle_o
);
  import jet_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = COUNT_WIDTH;

  typedef enum logic [3:0] {
    PH_ROOT, PH_VALUE, PH_ARR_FIRST, PH_OBJ_FIRST, PH_KEY, PH_COLON,
    PH_AFTER, PH_TRAIL, PH_STRING, PH_NUMBER, PH_LIT
  } phase_e;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] cap16(input logic [CW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  phase_e        phase_q, phase_d;
  logic [1:0]    word_q, word_d;
  logic [2:0]    lidx_q, lidx_d;
  logic          key_q, key_d, esc_q, esc_d, failed_q, failed_d;
  logic [DW-1:0] depth_q, depth_d;
  logic          tkind_q, tkind_d;
  logic [CW-1:0] tcnt_q, tcnt_d, slen_q, slen_d;
  logic [31:0]   pos_q, pos_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [CW:0]   wdata, rdata;

  jet_stack #(.DEPTH(STACK_DEPTH), .WIDTH(CW + 1)) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  jet_event_t [2:0] ev;
  logic [1:0]       n;

  always_comb begin
    phase_e      ph;
    logic [1:0]  lw;
    logic [2:0]  li;
    logic        key, esc, fl, tk, sv, opn, obj, cls, vd;
    logic [DW-1:0] dep;
    logic [CW-1:0] tc, sl;
    logic [7:0]  b, d;
    logic [31:0] lim;

    ph = phase_q; lw = word_q; li = lidx_q; key = key_q; esc = esc_q;
    fl = failed_q; dep = depth_q; tk = tkind_q; tc = tcnt_q; sl = slen_q;
    b = char_byte_i; d = 8'h00;
    sv = 1'b0; opn = 1'b0; obj = 1'b0; cls = 1'b0; vd = 1'b0;
    ev = '0; n = 2'd0;
    we = 1'b0; waddr = '0; wdata = '0;
    lim = (32'(depth_limit_i) > 32'(STACK_DEPTH)) ? 32'(STACK_DEPTH) : 32'(depth_limit_i);

    if (!fl) begin
      // a byte that cannot continue a number ends it first
      if (ph == PH_NUMBER && !is_num_char(b)) begin
        ev[n] = mk_ev(EV_NUM_END, 8'h00, 16'h0, ERR_EMPTY); n = n + 2'd1;
        if (dep != '0) begin tc = sat_inc(tc); ph = PH_AFTER; end
        else ph = PH_TRAIL;
      end
      case (ph)
        PH_NUMBER: begin
          ev[n] = mk_ev(EV_NUM_CHAR, b, 16'h0, ERR_EMPTY); n = n + 2'd1;
        end
        PH_ARR_FIRST: begin
          if (!is_ws(b)) begin
            if (b == "]") cls = 1'b1;
            else sv = 1'b1;
          end
        end
        PH_OBJ_FIRST, PH_KEY: begin
          if (!is_ws(b)) begin
            if (b == "}" && ph == PH_OBJ_FIRST) cls = 1'b1;
            else if (b == "\"") begin
              key = 1'b1; esc = 1'b0; sl = '0; ph = PH_STRING;
            end else begin
              ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_KEY_START); n = n + 2'd1; fl = 1'b1;
            end
          end
        end
        PH_COLON: begin
          if (!is_ws(b)) begin
            if (b == ":") ph = PH_VALUE;
            else begin
              ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_COLON); n = n + 2'd1; fl = 1'b1;
            end
          end
        end
        PH_AFTER: begin
          if (!is_ws(b)) begin
            if (b == ",") ph = tk ? PH_KEY : PH_VALUE;
            else if ((tk && b == "}") || (!tk && b == "]")) cls = 1'b1;
            else begin
              ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, tk ? ERR_OBJ_COMMA : ERR_ARR_COMMA);
              n = n + 2'd1; fl = 1'b1;
            end
          end
        end
        PH_TRAIL: begin
          if (!is_ws(b)) begin
            ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_NOT_SINGLE); n = n + 2'd1; fl = 1'b1;
          end
        end
        PH_STRING: begin
          if (esc) begin
            d = unescape(b);
            esc = 1'b0;
            if (d == 8'h00) begin
              ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_ESCAPE); n = n + 2'd1; fl = 1'b1;
            end else begin
              sl = sat_inc(sl);
              ev[n] = mk_ev(key ? EV_KEY_CHAR : EV_STR_CHAR, d, 16'h0, ERR_EMPTY);
              n = n + 2'd1;
            end
          end else if (b == "\\") begin
            esc = 1'b1;
          end else if (b == "\"") begin
            ev[n] = mk_ev(key ? EV_KEY_END : EV_STR_END, 8'h00, cap16(sl), ERR_EMPTY);
            n = n + 2'd1;
            if (key) begin key = 1'b0; ph = PH_COLON; end
            else vd = 1'b1;
          end else if (b == 8'h00) begin
            ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_UNTERM); n = n + 2'd1; fl = 1'b1;
          end else if (b < CtrlLimit) begin
            ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_ESCAPE); n = n + 2'd1; fl = 1'b1;
          end else begin
            sl = sat_inc(sl);
            ev[n] = mk_ev(key ? EV_KEY_CHAR : EV_STR_CHAR, b, 16'h0, ERR_EMPTY);
            n = n + 2'd1;
          end
        end
        PH_LIT: begin
          if (b != lit_char(lw, li)) begin
            ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_LITERAL); n = n + 2'd1; fl = 1'b1;
          end else begin
            li = li + 3'd1;
            if (li == lit_len(lw)) begin
              li = 3'd0;
              ev[n] = mk_ev(event_kind_e'(4'(EV_NULL) + 4'(lw)), 8'h00, 16'h0, ERR_EMPTY);
              n = n + 2'd1;
              vd = 1'b1;
            end
          end
        end
        default: begin
          if (!is_ws(b)) sv = 1'b1;
        end
      endcase

      if (sv) begin
        if (b == "n" || b == "t" || b == "f") begin
          lw = (b == "n") ? 2'd0 : ((b == "t") ? 2'd1 : 2'd2);
          li = 3'd1; ph = PH_LIT;
        end else if (b == "\"") begin
          key = 1'b0; esc = 1'b0; sl = '0; ph = PH_STRING;
        end else if (b == "[" || b == "{") begin
          opn = 1'b1; obj = (b == "{");
        end else if (is_num_char(b)) begin
          ph = PH_NUMBER;
          ev[n] = mk_ev(EV_NUM_CHAR, b, 16'h0, ERR_EMPTY); n = n + 2'd1;
        end else begin
          ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_NUMBER); n = n + 2'd1; fl = 1'b1;
        end
      end

      if (opn) begin
        if (32'(dep) >= lim) begin
          ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_TOO_DEEP); n = n + 2'd1; fl = 1'b1;
        end else begin
          // old top goes down into memory
          if (dep != '0) begin
            we = 1'b1; waddr = AW'(dep - 1'b1); wdata = {tk, tc};
          end
          tk = obj; tc = '0; dep = dep + 1'b1;
          ev[n] = mk_ev(obj ? EV_OBJ_START : EV_ARR_START, 8'h00, 16'h0, ERR_EMPTY);
          n = n + 2'd1;
          ph = obj ? PH_OBJ_FIRST : PH_ARR_FIRST;
        end
      end

      if (cls) begin
        dep = dep - 1'b1;
        ev[n] = mk_ev(tk ? EV_OBJ_END : EV_ARR_END, 8'h00, cap16(tc), ERR_EMPTY);
        n = n + 2'd1;
        // parent entry was prefetched from the slot below the top
        if (dep != '0) {tk, tc} = rdata;
        vd = 1'b1;
      end

      if (vd) begin
        if (dep != '0) begin tc = sat_inc(tc); ph = PH_AFTER; end
        else ph = PH_TRAIL;
      end
    end

    if (is_last_i && !fl) begin
      if (ph == PH_NUMBER) begin
        ev[n] = mk_ev(EV_NUM_END, 8'h00, 16'h0, ERR_EMPTY); n = n + 2'd1;
        ph = (dep != '0) ? PH_AFTER : PH_TRAIL;
      end
      case (ph)
        PH_TRAIL: begin
          ev[n] = mk_ev(EV_DOC_END, 8'h00, 16'h0, ERR_EMPTY);
        end
        PH_VALUE, PH_ARR_FIRST: ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_NUMBER);
        PH_OBJ_FIRST, PH_KEY:   ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_KEY_START);
        PH_COLON:               ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_COLON);
        PH_AFTER: begin
          ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, tk ? ERR_OBJ_COMMA : ERR_ARR_COMMA);
        end
        PH_STRING: begin
          ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, esc ? ERR_ESCAPE : ERR_UNTERM);
        end
        PH_LIT:  ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_LITERAL);
        default: ev[n] = mk_ev(EV_ERROR, 8'h00, 16'h0, ERR_EMPTY);
      endcase
      n = n + 2'd1;
    end

    if (is_last_i) begin
      ph = PH_ROOT; lw = 2'd0; li = 3'd0; key = 1'b0; esc = 1'b0;
      dep = '0; sl = '0; fl = 1'b0;
    end

    phase_d = ph; word_d = lw; lidx_d = li; key_d = key; esc_d = esc;
    failed_d = fl; depth_d = dep; tkind_d = tk; tcnt_d = tc; slen_d = sl;
    pos_d = is_last_i ? 32'h0 : ((pos_q == 32'hFFFF_FFFF) ? pos_q : pos_q + 32'h1);
    we = we & accept_i;
  end

  // keep the slot below the top prefetched
  always_comb begin
    logic [DW-1:0] dn;
    dn = accept_i ? depth_d : depth_q;
    raddr = (32'(dn) >= 32'd2) ? AW'(dn - 2'd2) : '0;
  end

  assign bundle_o.ev  = ev;
  assign bundle_o.num = n;
  assign bundle_o.pos = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_ROOT;
      word_q   <= 2'd0;
      lidx_q   <= 3'd0;
      key_q    <= 1'b0;
      esc_q    <= 1'b0;
      failed_q <= 1'b0;
      depth_q  <= '0;
      slen_q   <= '0;
      pos_q    <= 32'h0;
      tkind_q  <= 1'b0;
      tcnt_q   <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      word_q   <= word_d;
      lidx_q   <= lidx_d;
      key_q    <= key_d;
      esc_q    <= esc_d;
      failed_q <= failed_d;
      depth_q  <= depth_d;
      slen_q   <= slen_d;
      pos_q    <= pos_d;
      tkind_q  <= tkind_d;
      tcnt_q   <= tcnt_d;
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(depth_q) <= 32'(STACK_DEPTH))
    else $error("nesting depth beyond stack");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && is_last_i |=> depth_q == '0 && pos_q == 32'h0 && !failed_q)
    else $error("no restart after last byte");

  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q && !(accept_i && is_last_i) |=> failed_q)
    else $error("error state left early");

  a_silent_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q && accept_i && !is_last_i |-> bundle_o.num == 2'd0)
    else $error("events after error");

endmodule

@@ hdl/jet_out.sv @@
// ----------------------------------------------------------------------------
// jet_out
// Two-entry queue of per-byte event groups, sent out one event per cycle while out_o is ready.
// ----------------------------------------------------------------------------
module jet_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  jet_pkg::jet_bundle_t bundle_i,
  output logic                 ready_o,
  jet_event_if.source          out_o
);
  import jet_pkg::*;

  jet_bundle_t q_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q, sel_q;
  jet_bundle_t head;
  logic        last, pop;

  assign head    = q_q[rptr_q];
  assign last    = (sel_q == (head.num - 2'd1));
  assign pop     = out_o.valid && out_o.ready && last;
  assign ready_o = (cnt_q != 2'd2);

  assign out_o.valid         = (cnt_q != 2'd0);
  assign out_o.event_kind    = head.ev[sel_q].kind;
  assign out_o.char_value    = head.ev[sel_q].ch;
  assign out_o.item_count    = head.ev[sel_q].cnt;
  assign out_o.error_code    = head.ev[sel_q].err;
  assign out_o.byte_position = head.pos;
  assign out_o.last_of_run   = last;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q[wptr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
      sel_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop) begin
        rptr_q <= ~rptr_q;
        sel_q  <= 2'd0;
      end else if (out_o.valid && out_o.ready) begin
        sel_q <= sel_q + 2'd1;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2)
    else $error("event queue overflow");

  a_group_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> head.num != 2'd0 && sel_q < head.num)
    else $error("bad event group index");

  a_pop_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> sel_q == 2'd0)
    else $error("group index not cleared");

endmodule
